// ===== rtl/core/rmc_pkg.sv =====
// rmc_pkg: constants, result word type and small decode helpers for the
// $GPRMC sentence decoder. No dependencies.
package rmc_pkg;

	localparam int unsigned SlotCount = 38;
	localparam int unsigned SlotIdxW  = 6;
	localparam int unsigned HdrLen    = 6;

	localparam logic [7:0] CharComma = 8'h2C;
	localparam logic [7:0] CharFill  = 8'h25;
	localparam logic [7:0] CharZero  = 8'h30;
	localparam logic [7:0] CharNine  = 8'h39;

	localparam logic [3:0] CommaEnd  = 4'd9;
	localparam logic [4:0] HourOffsetRst = 5'd18;

	// one decoded sentence
	typedef struct packed {
		logic [4:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
		logic [6:0]  lat_degrees;
		logic [6:0]  lat_minutes;
		logic [5:0]  lat_seconds;
		logic [9:0]  lon_degrees;
		logic [6:0]  lon_minutes;
		logic [5:0]  lon_seconds;
		logic [15:0] hemispheres;
		logic [22:0] date_packed;
		logic        malformed;
	} rmc_result_t;

	// expected header character at a given match position
	function automatic logic [7:0] hdr_char(input logic [2:0] pos);
		logic [7:0] c;
		unique case (pos)
			3'd0: c = 8'h24; // '$'
			3'd1: c = 8'h47; // 'G'
			3'd2: c = 8'h50; // 'P'
			3'd3: c = 8'h52; // 'R'
			3'd4: c = 8'h4D; // 'M'
			3'd5: c = 8'h43; // 'C'
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CharZero) && (c <= CharNine);
	endfunction

	// digit value, non-digits count as zero
	function automatic logic [3:0] dig_val(input logic [7:0] c);
		logic [7:0] d;
		d = c - CharZero;
		return is_digit(c) ? d[3:0] : 4'd0;
	endfunction

	// hi*10 + lo from two characters
	function automatic logic [6:0] two_dig(input logic [7:0] hi, input logic [7:0] lo);
		logic [6:0] h;
		h = {3'b000, dig_val(hi)};
		return (h << 3) + (h << 1) + {3'b000, dig_val(lo)};
	endfunction

	// floor(x*60/100) = floor(3x/5), reciprocal of 5 in 16 fractional bits
	function automatic logic [5:0] scale60(input logic [6:0] x);
		logic [8:0]  p;
		logic [22:0] m;
		p = {2'b00, x} + {1'b0, x, 1'b0};
		m = {14'd0, p} * 23'd13108;
		return m[21:16];
	endfunction

	// v mod 24 for v up to 130, quotient by reciprocal
	function automatic logic [4:0] mod24(input logic [7:0] v);
		logic [19:0] m;
		logic [7:0]  q;
		logic [7:0]  r;
		m = {12'd0, v} * 20'd2731;
		q = {5'd0, m[18:16]};
		r = v - ((q << 4) + (q << 3));
		return r[4:0];
	endfunction

endpackage

// ===== rtl/core/nmea_rmc_sentence_decoder_unit.sv =====
// The comma that ends a sentence is taken into the input register; its result word
// is then loaded into the result register, once no stalled word holds the output.
// Throughput: one character per cycle; the input stalls only while a finished
// word waits at the output and out_ready is low.
// Reset: header match, comma count, slot index and overflow flag clear, all
// 38 slots read as '%', hour offset returns to 18, no word is pending.
// Top level of the $GPRMC decoder; uses rmc_pkg.
module nmea_rmc_sentence_decoder_unit
	import rmc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  hour,
	output logic [6:0]  minute,
	output logic [6:0]  second,
	output logic [6:0]  lat_degrees,
	output logic [6:0]  lat_minutes,
	output logic [5:0]  lat_seconds,
	output logic [9:0]  lon_degrees,
	output logic [6:0]  lon_minutes,
	output logic [5:0]  lon_seconds,
	output logic [15:0] hemispheres,
	output logic [22:0] date_packed,
	output logic        malformed
);

	logic [4:0]          hour_offset_q;
	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic [2:0]          hdr_pos_q;
	logic [3:0]          comma_cnt_q;
	logic [SlotIdxW-1:0] slot_idx_q;
	logic [SlotCount-1:0] slot_vld_q;
	logic [7:0]          slot_q [SlotCount];
	logic                ovf_q;
	logic                out_valid_q;
	rmc_result_t         res_q;

	logic        hdr_done;
	logic        is_comma;
	logic        emit_s1;
	logic        store_s1;
	logic        slot_free;
	logic        out_load_ok;
	logic        adv_s1;
	logic [7:0]  ch [SlotCount];
	rmc_result_t res_d;

	// stage control
	assign hdr_done    = (hdr_pos_q == 3'(HdrLen));
	assign is_comma    = (byte_s1 == CharComma);
	assign emit_s1     = valid_s1 && hdr_done && is_comma && (comma_cnt_q == CommaEnd);
	assign store_s1    = hdr_done && !is_comma &&
		(((comma_cnt_q >= 4'd1) && (comma_cnt_q <= 4'd6)) || (comma_cnt_q == CommaEnd));
	assign slot_free   = (slot_idx_q < SlotIdxW'(SlotCount));
	assign out_load_ok = !out_valid_q || out_ready;
	assign adv_s1      = valid_s1 && (!emit_s1 || out_load_ok);
	assign in_ready    = !valid_s1 || adv_s1;

	// hour offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_offset_q <= HourOffsetRst;
		end else if (cfg_we) begin
			hour_offset_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	// sentence tracking: header match, commas, slot fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos_q   <= '0;
			comma_cnt_q <= '0;
			slot_idx_q  <= '0;
			slot_vld_q  <= '0;
			ovf_q       <= 1'b0;
		end else if (adv_s1) begin
			if (!hdr_done) begin
				if (byte_s1 == hdr_char(hdr_pos_q)) begin
					hdr_pos_q <= hdr_pos_q + 3'd1;
				end
			end else if (is_comma) begin
				if (comma_cnt_q == CommaEnd) begin
					hdr_pos_q   <= '0;
					comma_cnt_q <= '0;
					slot_idx_q  <= '0;
					slot_vld_q  <= '0;
					ovf_q       <= 1'b0;
				end else begin
					comma_cnt_q <= comma_cnt_q + 4'd1;
				end
			end else if (store_s1) begin
				if (slot_free) begin
					slot_vld_q[slot_idx_q] <= 1'b1;
					slot_idx_q <= slot_idx_q + SlotIdxW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	// slot characters, written once per stored character
	always_ff @(posedge clk) begin
		if (adv_s1 && store_s1 && slot_free) begin
			slot_q[slot_idx_q] <= byte_s1;
		end
	end

	// slots never written since the last clear read as fill
	always_comb begin
		for (int i = 0; i < SlotCount; i++) begin
			ch[i] = slot_vld_q[i] ? slot_q[i] : CharFill;
		end
	end

	// decode the fixed slot layout
	always_comb begin
		logic       bad;
		logic [6:0] hh;
		logic [9:0] d21;
		bad = 1'b0;
		// only slots that feed a decoded digit count, the decimal points do not
		for (int i = 0; i < SlotCount; i++) begin
			if ((i <= 5) || ((i >= 11) && (i <= 14)) || (i == 16) || (i == 17) ||
					((i >= 21) && (i <= 25)) || (i == 27) || (i == 28) || (i >= 32)) begin
				bad = bad | !is_digit(ch[i]);
			end
		end
		hh  = two_dig(ch[0], ch[1]);
		d21 = {6'd0, dig_val(ch[21])};
		res_d.hour        = mod24({1'b0, hh} + {3'b000, hour_offset_q});
		res_d.minute      = two_dig(ch[2], ch[3]);
		res_d.second      = two_dig(ch[4], ch[5]);
		res_d.lat_degrees = two_dig(ch[11], ch[12]);
		res_d.lat_minutes = two_dig(ch[13], ch[14]);
		res_d.lat_seconds = scale60(two_dig(ch[16], ch[17]));
		res_d.lon_degrees = (d21 << 6) + (d21 << 5) + (d21 << 2) +
			{3'b000, two_dig(ch[22], ch[23])};
		res_d.lon_minutes = two_dig(ch[24], ch[25]);
		res_d.lon_seconds = scale60(two_dig(ch[27], ch[28]));
		res_d.hemispheres = {ch[20], ch[31]};
		res_d.date_packed = {two_dig(ch[32], ch[33]), 1'b0, two_dig(ch[34], ch[35]),
			1'b0, two_dig(ch[36], ch[37])};
		res_d.malformed   = bad | ovf_q;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit_s1) begin
			res_q <= res_d;
		end
	end

	// output word
	assign out_valid   = out_valid_q;
	assign hour        = res_q.hour;
	assign minute      = res_q.minute;
	assign second      = res_q.second;
	assign lat_degrees = res_q.lat_degrees;
	assign lat_minutes = res_q.lat_minutes;
	assign lat_seconds = res_q.lat_seconds;
	assign lon_degrees = res_q.lon_degrees;
	assign lon_minutes = res_q.lon_minutes;
	assign lon_seconds = res_q.lon_seconds;
	assign hemispheres = res_q.hemispheres;
	assign date_packed = res_q.date_packed;
	assign malformed   = res_q.malformed;

endmodule

// ===== rtl/core/rmc_checker.sv =====
// rmc_checker: port-level assertions for the $GPRMC decoder, bound to the
// top level. Depends on nmea_rmc_sentence_decoder_unit ports only.
module rmc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [4:0]  hour,
	input logic [5:0]  lat_seconds,
	input logic [5:0]  lon_seconds,
	input logic [22:0] date_packed
);

	// a stalled word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	// a stalled word keeps its hour and date fields
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(hour) && $stable(date_packed))
		else $error("output word changed while stalled");

	// hour wraps modulo 24 for any offset
	a_hour_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hour < 5'd24)
		else $error("hour out of range");

	// scaled fractions stay below 60
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (lat_seconds < 6'd60) && (lon_seconds < 6'd60))
		else $error("scaled seconds out of range");

endmodule

bind nmea_rmc_sentence_decoder_unit rmc_checker u_rmc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.hour       (hour),
	.lat_seconds(lat_seconds),
	.lon_seconds(lon_seconds),
	.date_packed(date_packed)
);

// ===== dv/nmea_rmc_sentence_decoder_unit_tb.sv =====
// testbench for nmea_rmc_sentence_decoder_unit: streams $GPRMC sentences, noise and
// broken text through the character port and checks each decoded word against a
// local sentence decoder; depends on rmc_pkg and the decoder rtl only
module testbench;
	import rmc_pkg::*;

	// sentence fields in comma order after the header
	typedef enum int {
		FldTime = 1,
		FldStatus,
		FldLat,
		FldNs,
		FldLon,
		FldEw,
		FldSpeed,
		FldCourse,
		FldDate
	} rmc_field_e;

	localparam logic [47:0] SentenceTag = "$GPRMC";
	localparam int          TagLen      = 6;
	localparam int          FixEndComma = 10;
	localparam logic [7:0]  CharDot     = 8'h2E;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [4:0]  cfg_wdata = 5'd0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte   = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [4:0]  hour;
	logic [6:0]  minute;
	logic [6:0]  second;
	logic [6:0]  lat_degrees;
	logic [6:0]  lat_minutes;
	logic [5:0]  lat_seconds;
	logic [9:0]  lon_degrees;
	logic [6:0]  lon_minutes;
	logic [5:0]  lon_seconds;
	logic [15:0] hemispheres;
	logic [22:0] date_packed;
	logic        malformed;

	nmea_rmc_sentence_decoder_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hour       (hour),
		.minute     (minute),
		.second     (second),
		.lat_degrees(lat_degrees),
		.lat_minutes(lat_minutes),
		.lat_seconds(lat_seconds),
		.lon_degrees(lon_degrees),
		.lon_minutes(lon_minutes),
		.lon_seconds(lon_seconds),
		.hemispheres(hemispheres),
		.date_packed(date_packed),
		.malformed  (malformed)
	);

	// characters waiting to be sent and decoded words still due
	logic [7:0]  rx_chars[$];
	rmc_result_t fixes_due[$];

	// local decoder state
	logic [4:0]  utc_offset = HourOffsetRst;
	int          tag_pos    = 0;
	int          commas     = 0;
	int          slot_idx   = 0;
	logic [7:0]  slots[SlotCount];
	bit          slots_spilled = 1'b0;
	bit          digit_bad;

	int word_errors = 0;
	int send_gap    = 0;
	int send_calm   = 0;
	int take_gap    = 0;
	int take_calm   = 0;
	int chars_built = 0;
	int digit_mode  = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// digit value of a slot, non-digits read as zero and flag the word
	function automatic int slot_digit(input int s);
		if (slots[s] < 8'h30 || slots[s] > 8'h39) begin
			digit_bad = 1'b1;
			return 0;
		end
		return int'(slots[s]) - 48;
	endfunction

	function automatic int slot_pair(input int s);
		int hi;
		hi = slot_digit(s);
		return hi * 10 + slot_digit(s + 1);
	endfunction

	function automatic void clear_slots();
		foreach (slots[i])
			slots[i] = CharFill;
		tag_pos       = 0;
		commas        = 0;
		slot_idx      = 0;
		slots_spilled = 1'b0;
	endfunction

	// advance the sentence decoder by one character, queue a word on the last comma
	function automatic void decode_char(input logic [7:0] c);
		rmc_result_t fix;
		if (tag_pos < TagLen) begin
			if (c == SentenceTag[47 - 8 * tag_pos -: 8]) begin
				tag_pos++;
				if (tag_pos == TagLen)
					slot_idx = 0;
			end
		end else if (c == CharComma) begin
			commas++;
			if (commas == FixEndComma) begin
				digit_bad       = 1'b0;
				fix.hour        = 5'((slot_pair(0) + int'(utc_offset)) % 24);
				fix.minute      = 7'(slot_pair(2));
				fix.second      = 7'(slot_pair(4));
				fix.lat_degrees = 7'(slot_pair(11));
				fix.lat_minutes = 7'(slot_pair(13));
				fix.lat_seconds = 6'(slot_pair(16) * 60 / 100);
				fix.lon_degrees = 10'(slot_digit(21) * 100 + slot_pair(22));
				fix.lon_minutes = 7'(slot_pair(24));
				fix.lon_seconds = 6'(slot_pair(27) * 60 / 100);
				fix.hemispheres = {slots[20], slots[31]};
				fix.date_packed = 23'((slot_pair(32) << 16) | (slot_pair(34) << 8)
					| slot_pair(36));
				fix.malformed   = digit_bad || slots_spilled;
				fixes_due.push_back(fix);
				clear_slots();
			end
		end else if ((commas >= FldTime && commas <= FldEw) || commas == FldDate) begin
			// speed and course text never reaches the slots
			if (slot_idx < SlotCount) begin
				slots[slot_idx] = c;
				slot_idx++;
			end else begin
				slots_spilled = 1'b1;
			end
		end
	endfunction

	function automatic string fix_text(input rmc_result_t f);
		return {$sformatf("hour=%0d min=%0d sec=%0d lat=%0d/%0d/%0d ",
				f.hour, f.minute, f.second, f.lat_degrees, f.lat_minutes, f.lat_seconds),
			$sformatf("lon=%0d/%0d/%0d hemi=%h date=%h bad=%0d",
				f.lon_degrees, f.lon_minutes, f.lon_seconds, f.hemispheres, f.date_packed,
				f.malformed)};
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] any_but_comma();
		logic [7:0] r;
		do
			r = 8'($urandom_range(0, 255));
		while (r == CharComma);
		return r;
	endfunction

	function automatic logic [7:0] digit_char();
		case (digit_mode)
			0: return 8'h39;
			1: return 8'h30;
			default: return 8'($urandom_range(0, 9) + 48);
		endcase
	endfunction

	task automatic push_text(input string t);
		for (int i = 0; i < t.len(); i++)
			rx_chars.push_back(t[i]);
	endtask

	// one sentence: mostly well formed, some shifted, overflowing or cut short
	task automatic build_sentence();
		logic [7:0] s[$];
		int mode;
		int len;
		int dot;
		int idx;
		logic [7:0] alt0;
		logic [7:0] alt1;
		mode       = $urandom_range(0, 99);
		digit_mode = $urandom_range(0, 9);
		repeat ($urandom_range(0, 3))
			rx_chars.push_back(8'($urandom_range(0, 255)));
		for (int k = 0; k < TagLen; k++)
			s.push_back(SentenceTag[47 - 8 * k -: 8]);
		s.push_back(CharComma);
		for (int fld = FldTime; fld <= FldDate; fld++) begin
			dot  = -1;
			alt0 = 8'h00;
			alt1 = 8'h00;
			case (rmc_field_e'(fld))
				FldTime: begin
					len = 10;
					dot = 6;
				end
				FldStatus: begin
					len  = 1;
					alt0 = "A";
					alt1 = "V";
				end
				FldLat: begin
					len = 9;
					dot = 4;
				end
				FldNs: begin
					len  = 1;
					alt0 = "N";
					alt1 = "S";
				end
				FldLon: begin
					len = 10;
					dot = 5;
				end
				FldEw: begin
					len  = 1;
					alt0 = "E";
					alt1 = "W";
				end
				FldDate: len = 6;
				default: begin
					len = $urandom_range(0, 5);
					dot = 2;
				end
			endcase
			if (mode >= 75 && mode < 85)
				len = $urandom_range(0, 12);
			if (mode >= 85 && mode < 93 && fld == FldTime)
				len = $urandom_range(30, 45);
			for (int k = 0; k < len; k++) begin
				if (alt0 != 8'h00)
					s.push_back(($urandom_range(0, 7) == 0) ? any_but_comma()
						: ($urandom_range(0, 1) ? alt0 : alt1));
				else if (k == dot)
					s.push_back(CharDot);
				else
					s.push_back(digit_char());
			end
			s.push_back(CharComma);
		end
		// stray character inside a field
		if (mode < 75 && $urandom_range(0, 5) == 0) begin
			idx = $urandom_range(TagLen + 1, s.size() - 1);
			if (s[idx] != CharComma)
				s[idx] = any_but_comma();
		end
		if (mode >= 93)
			s = s[0 : $urandom_range(0, s.size() - 2)];
		foreach (s[i])
			rx_chars.push_back(s[i]);
		chars_built += s.size();
		if ($urandom_range(0, 1))
			push_text(",*4F\r\n");
	endtask

	task automatic wait_drained();
		while (rx_chars.size() != 0 || in_valid || fixes_due.size() != 0)
			@(posedge clk);
		// let characters that make no word clear the pipeline
		repeat (4) @(posedge clk);
	endtask

	task automatic set_offset(input logic [4:0] v);
		@(posedge clk);
		cfg_we     <= 1'b1;
		cfg_wdata  <= v;
		utc_offset = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// character driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte  <= 8'h00;
		end else begin
			if (in_valid && in_ready)
				decode_char(rx_byte);
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					in_valid <= 1'b0;
					send_gap--;
				end else if (rx_chars.size() != 0) begin
					rx_byte  <= rx_chars.pop_front();
					in_valid <= 1'b1;
					if (send_calm != 0) begin
						send_calm--;
					end else begin
						send_gap = pick_idle();
						if ($urandom_range(0, 149) == 0)
							send_calm = $urandom_range(80, 250);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// decoded word monitor
	always @(posedge clk or negedge arst_n) begin
		rmc_result_t got;
		rmc_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got = {hour, minute, second, lat_degrees, lat_minutes, lat_seconds,
					lon_degrees, lon_minutes, lon_seconds, hemispheres, date_packed, malformed};
				if (fixes_due.size() == 0) begin
					if (word_errors < 10)
						$display("unexpected word: %s", fix_text(got));
					word_errors++;
				end else begin
					want = fixes_due.pop_front();
					if (got !== want) begin
						if (word_errors < 10)
							$display("word mismatch\n  expected %s\n  actual   %s",
								fix_text(want), fix_text(got));
						word_errors++;
					end
				end
			end
			if (take_gap != 0) begin
				out_ready <= 1'b0;
				take_gap--;
			end else begin
				out_ready <= 1'b1;
				if (take_calm != 0) begin
					take_calm--;
				end else begin
					take_gap = pick_idle();
					if ($urandom_range(0, 149) == 0)
						take_calm = $urandom_range(80, 250);
				end
			end
		end
	end

	// stimulus phases
	initial begin
		logic [4:0] phase_offsets[6];
		int mark;
		int n;
		phase_offsets = '{5'd0, 5'd23, 5'd31, 5'd0, 5'd1, 5'd0};
		phase_offsets[3] = 5'($urandom_range(2, 22));
		phase_offsets[5] = 5'($urandom_range(0, 31));
		clear_slots();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// byte extremes, comma before the header and stray byte inside it, percent and empty fields
		rx_chars.push_back(8'h00);
		rx_chars.push_back(8'hFF);
		push_text(",$GxPRMC,%9,,,,,,,,,");

		foreach (phase_offsets[p]) begin
			wait_drained();
			set_offset(phase_offsets[p]);
			mark = chars_built;
			n    = 0;
			while (n < 3 || chars_built - mark < 210) begin
				build_sentence();
				n++;
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (word_errors == 0 && fixes_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// hard stop
	initial begin
		#20000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
